// ===== hw/rtl/rigid_transform_vertex_aabb_unit_defines.svh =====
// assertion helpers shared by the rigid transform unit
// every check samples on the rising clock edge and is off during reset
`ifndef RIGID_TRANSFORM_VERTEX_AABB_UNIT_DEFINES_SVH
`define RIGID_TRANSFORM_VERTEX_AABB_UNIT_DEFINES_SVH

// same-cycle implication
`define RTVA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RTVA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rtva_pkg.sv =====
package rtva_pkg;

   // fixed field widths
   localparam int COORD_W     = 32;
   localparam int QUAT_W      = 16;
   localparam int CSR_INDEX_W = 3;
   localparam int STEP_W      = 4;

   localparam logic [STEP_W-1:0] LAST_STEP = 4'd15;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_POS_X  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_Y  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_POS_Z  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_QUAT_W = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_QUAT_X = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_QUAT_Y = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_QUAT_Z = 3'd6;

   typedef struct packed {
      logic signed [COORD_W-1:0] vert_x;
      logic signed [COORD_W-1:0] vert_y;
      logic signed [COORD_W-1:0] vert_z;
      logic                      last_vertex;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] world_x;
      logic signed [COORD_W-1:0] world_y;
      logic signed [COORD_W-1:0] world_z;
      logic                      box_valid;
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_min_z;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_max_y;
      logic signed [COORD_W-1:0] box_max_z;
   } rsp_payload_type;

   // quaternion operand of the shared multiplier
   typedef enum logic [1:0] {
      QSEL_W,
      QSEL_X,
      QSEL_Y,
      QSEL_Z
   } qsel_type;

   // vector operand of the shared multiplier
   typedef enum logic [2:0] {
      BSEL_VX,
      BSEL_VY,
      BSEL_VZ,
      BSEL_A0,
      BSEL_A1,
      BSEL_A2
   } bsel_type;

   // where the finished accumulator goes at this step
   typedef enum logic [2:0] {
      STORE_NONE,
      STORE_A0,
      STORE_A1,
      STORE_A2,
      STORE_W0,
      STORE_W1,
      STORE_W2
   } store_type;

   typedef struct packed {
      logic      mul_en;
      logic      clr;
      logic      sub;
      qsel_type  qsel;
      bsel_type  bsel;
      store_type store;
   } step_ctrl_type;

   // microcode: a = u x v, then s = w*a + u x a, one product per step but the last
   function automatic step_ctrl_type step_ctrl(input logic [STEP_W-1:0] step);
      step_ctrl_type c;
      c = '{mul_en: 1'b1, clr: 1'b0, sub: 1'b0, qsel: QSEL_W, bsel: BSEL_VX,
            store: STORE_NONE};
      case (step)
         4'd0: begin
            c.clr = 1'b1; c.qsel = QSEL_Y; c.bsel = BSEL_VZ;
         end
         4'd1: begin
            c.sub = 1'b1; c.qsel = QSEL_Z; c.bsel = BSEL_VY;
         end
         4'd2: begin
            c.clr = 1'b1; c.qsel = QSEL_Z; c.bsel = BSEL_VX; c.store = STORE_A0;
         end
         4'd3: begin
            c.sub = 1'b1; c.qsel = QSEL_X; c.bsel = BSEL_VZ;
         end
         4'd4: begin
            c.clr = 1'b1; c.qsel = QSEL_X; c.bsel = BSEL_VY; c.store = STORE_A1;
         end
         4'd5: begin
            c.sub = 1'b1; c.qsel = QSEL_Y; c.bsel = BSEL_VX;
         end
         4'd6: begin
            c.clr = 1'b1; c.qsel = QSEL_W; c.bsel = BSEL_A0; c.store = STORE_A2;
         end
         4'd7: begin
            c.qsel = QSEL_Y; c.bsel = BSEL_A2;
         end
         4'd8: begin
            c.sub = 1'b1; c.qsel = QSEL_Z; c.bsel = BSEL_A1;
         end
         4'd9: begin
            c.clr = 1'b1; c.qsel = QSEL_W; c.bsel = BSEL_A1; c.store = STORE_W0;
         end
         4'd10: begin
            c.qsel = QSEL_Z; c.bsel = BSEL_A0;
         end
         4'd11: begin
            c.sub = 1'b1; c.qsel = QSEL_X; c.bsel = BSEL_A2;
         end
         4'd12: begin
            c.clr = 1'b1; c.qsel = QSEL_W; c.bsel = BSEL_A2; c.store = STORE_W1;
         end
         4'd13: begin
            c.qsel = QSEL_X; c.bsel = BSEL_A1;
         end
         4'd14: begin
            c.sub = 1'b1; c.qsel = QSEL_Y; c.bsel = BSEL_A0;
         end
         4'd15: begin
            c.mul_en = 1'b0; c.store = STORE_W2;
         end
         default: begin
            c.mul_en = 1'b0;
         end
      endcase
      return c;
   endfunction

endpackage

// ===== hw/rtl/rigid_transform_vertex_aabb_unit.sv =====
// Rigid transform unit: rotates each local vertex by a unit quaternion,
// adds the body position and tracks the axis-aligned box of the set.
// req channel: one vertex per item (valid/stall); last_vertex closes a set.
// rsp channel: one result per item with the world vertex and the box so far;
//    box_valid marks the result of the last vertex, whose box is final.
// csr channel: valid/ready write of a register index and data, ready is
//    always high; write only while no item is in flight.
// Flow: an accepted item runs through the multiply sequencer (BUSY), then
//    its result and the updated box load together into the output register
//    once it is free (DONE); a new item is taken only in IDLE. All 15
//    products go through one shared 16-bit by MB_W-bit multiplier, one per cycle.
// The output register holds a finished result while rsp_stall is high; the
//    next item is still accepted and computed, then waits for that register.
// Reset: position zero, quaternion identity, box cleared, next vertex starts
//    a new box, both channels empty.
`include "rigid_transform_vertex_aabb_unit_defines.svh"

module rigid_transform_vertex_aabb_unit
   import rtva_pkg::*;
#(
   parameter int QUAT_FRAC_BITS = 14
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_payload_type        req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_payload_type        rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]     csr_wdata
);

   // datapath widths
   localparam int A_W   = COORD_W + QUAT_W + 2 - QUAT_FRAC_BITS;
   localparam int MB_W  = (A_W > COORD_W) ? A_W : COORD_W;
   localparam int P_W   = QUAT_W + MB_W;
   localparam int ACC_W = P_W + 3;
   localparam int WS_W  = ACC_W + 2;

   localparam logic signed [ACC_W-1:0] HALF_A = ACC_W'(1) <<< (QUAT_FRAC_BITS - 1);
   localparam logic signed [ACC_W:0]   HALF_D = (ACC_W + 1)'(1) <<< (QUAT_FRAC_BITS - 1);
   localparam logic signed [WS_W-1:0]  SAT_HI = (WS_W'(1) <<< (COORD_W - 1)) - WS_W'(1);
   localparam logic signed [WS_W-1:0]  SAT_LO = -SAT_HI - WS_W'(1);
   localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1) <<< QUAT_FRAC_BITS;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_BUSY = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic signed [COORD_W-1:0] pos_ff [3];
   logic signed [QUAT_W-1:0]  qw_ff, qx_ff, qy_ff, qz_ff;

   logic signed [COORD_W-1:0] vert_ff [3];
   logic                      last_ff;
   logic signed [A_W-1:0]     a_ff [3];
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [COORD_W-1:0] world_ff [3];

   logic signed [COORD_W-1:0] run_min_ff [3], run_min_in [3];
   logic signed [COORD_W-1:0] run_max_ff [3], run_max_in [3];
   logic                      first_pending_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   step_ctrl_type           ctrl;
   logic signed [QUAT_W-1:0] mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [P_W-1:0]    prod;
   logic signed [ACC_W-1:0]  acc_base;
   logic signed [ACC_W-1:0]  a_round;
   logic signed [ACC_W:0]    d_round;
   logic signed [ACC_W:0]    d_val;
   logic signed [COORD_W-1:0] sel_vert, sel_pos;
   logic signed [WS_W-1:0]   world_sum;
   logic signed [COORD_W-1:0] world_sat;
   logic                     req_take, out_free, out_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign out_load  = (state_ff == ST_DONE) && out_free;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_BUSY;
               step_in  = '0;
            end
         end
         ST_BUSY: begin
            if (step_ff == LAST_STEP) begin
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff[0] <= '0;
         pos_ff[1] <= '0;
         pos_ff[2] <= '0;
         qw_ff     <= QUAT_ONE;
         qx_ff     <= '0;
         qy_ff     <= '0;
         qz_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_POS_X:  pos_ff[0] <= csr_wdata;
            REG_POS_Y:  pos_ff[1] <= csr_wdata;
            REG_POS_Z:  pos_ff[2] <= csr_wdata;
            REG_QUAT_W: qw_ff     <= csr_wdata[QUAT_W-1:0];
            REG_QUAT_X: qx_ff     <= csr_wdata[QUAT_W-1:0];
            REG_QUAT_Y: qy_ff     <= csr_wdata[QUAT_W-1:0];
            REG_QUAT_Z: qz_ff     <= csr_wdata[QUAT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // capture the incoming vertex
   always_ff @(posedge clock) begin
      if (req_take) begin
         vert_ff[0] <= req_payload.vert_x;
         vert_ff[1] <= req_payload.vert_y;
         vert_ff[2] <= req_payload.vert_z;
         last_ff    <= req_payload.last_vertex;
      end
   end

   // shared multiplier operand select
   assign ctrl = step_ctrl(step_ff);

   always_comb begin
      case (ctrl.qsel)
         QSEL_W:  mul_a = qw_ff;
         QSEL_X:  mul_a = qx_ff;
         QSEL_Y:  mul_a = qy_ff;
         QSEL_Z:  mul_a = qz_ff;
         default: mul_a = qw_ff;
      endcase
      case (ctrl.bsel)
         BSEL_VX: mul_b = MB_W'(vert_ff[0]);
         BSEL_VY: mul_b = MB_W'(vert_ff[1]);
         BSEL_VZ: mul_b = MB_W'(vert_ff[2]);
         BSEL_A0: mul_b = MB_W'(a_ff[0]);
         BSEL_A1: mul_b = MB_W'(a_ff[1]);
         BSEL_A2: mul_b = MB_W'(a_ff[2]);
         default: mul_b = MB_W'(vert_ff[0]);
      endcase
   end

   assign prod = mul_a * mul_b;

   // multiply-accumulate
   always_comb begin
      acc_base = ctrl.clr ? '0 : acc_ff;
      if (ctrl.sub) begin
         acc_in = acc_base - ACC_W'(prod);
      end else begin
         acc_in = acc_base + ACC_W'(prod);
      end
   end

   // rounding of the cross product and of the doubled rotation term
   assign a_round = (acc_ff + HALF_A) >>> QUAT_FRAC_BITS;
   assign d_round = $signed({acc_ff, 1'b0}) + HALF_D;
   assign d_val   = d_round >>> QUAT_FRAC_BITS;

   // world coordinate of the axis being stored, saturated
   always_comb begin
      case (ctrl.store)
         STORE_W0: begin
            sel_vert = vert_ff[0];
            sel_pos  = pos_ff[0];
         end
         STORE_W1: begin
            sel_vert = vert_ff[1];
            sel_pos  = pos_ff[1];
         end
         STORE_W2: begin
            sel_vert = vert_ff[2];
            sel_pos  = pos_ff[2];
         end
         default: begin
            sel_vert = vert_ff[0];
            sel_pos  = pos_ff[0];
         end
      endcase
      world_sum = WS_W'(d_val) + WS_W'(sel_vert) + WS_W'(sel_pos);
      if (world_sum > SAT_HI) begin
         world_sat = COORD_W'(SAT_HI);
      end else if (world_sum < SAT_LO) begin
         world_sat = COORD_W'(SAT_LO);
      end else begin
         world_sat = COORD_W'(world_sum);
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_BUSY) begin
         if (ctrl.mul_en) begin
            acc_ff <= acc_in;
         end
         case (ctrl.store)
            STORE_A0: a_ff[0]     <= A_W'(a_round);
            STORE_A1: a_ff[1]     <= A_W'(a_round);
            STORE_A2: a_ff[2]     <= A_W'(a_round);
            STORE_W0: world_ff[0] <= world_sat;
            STORE_W1: world_ff[1] <= world_sat;
            STORE_W2: world_ff[2] <= world_sat;
            default: begin
            end
         endcase
      end
   end

   // running box, restarted by the first vertex of a set
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (first_pending_ff) begin
            run_min_in[i] = world_ff[i];
            run_max_in[i] = world_ff[i];
         end else begin
            run_min_in[i] = (world_ff[i] < run_min_ff[i]) ? world_ff[i] : run_min_ff[i];
            run_max_in[i] = (world_ff[i] > run_max_ff[i]) ? world_ff[i] : run_max_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            run_min_ff[i] <= '0;
            run_max_ff[i] <= '0;
         end
         first_pending_ff <= 1'b1;
      end else if (out_load) begin
         for (int i = 0; i < 3; i++) begin
            run_min_ff[i] <= run_min_in[i];
            run_max_ff[i] <= run_max_in[i];
         end
         first_pending_ff <= last_ff;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in     = 1'b1;
         rsp_in.world_x   = world_ff[0];
         rsp_in.world_y   = world_ff[1];
         rsp_in.world_z   = world_ff[2];
         rsp_in.box_valid = last_ff;
         rsp_in.box_min_x = run_min_in[0];
         rsp_in.box_min_y = run_min_in[1];
         rsp_in.box_min_z = run_min_in[2];
         rsp_in.box_max_x = run_max_in[0];
         rsp_in.box_max_y = run_max_in[1];
         rsp_in.box_max_z = run_max_in[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   // checks
   `RTVA_ASSERT_NEXT(a_take_starts, req_valid && !req_stall, state_ff == ST_BUSY && step_ff == '0, "accepted item did not start the sequencer")
   `RTVA_ASSERT_NEXT(a_done_loads, state_ff == ST_DONE && out_free, rsp_valid && state_ff == ST_IDLE, "finished item not loaded into output")
   `RTVA_ASSERT_NEXT(a_rearm, state_ff == ST_DONE && out_free, first_pending_ff == rsp_payload.box_valid, "box re-arm does not follow the last vertex")
   `RTVA_ASSERT_NOW(a_box_order, rsp_valid, ($signed(rsp_payload.box_min_x) <= $signed(rsp_payload.box_max_x)) && ($signed(rsp_payload.box_min_y) <= $signed(rsp_payload.box_max_y)) && ($signed(rsp_payload.box_min_z) <= $signed(rsp_payload.box_max_z)), "box minimum above maximum")

endmodule

// ===== bench/tb_rigid_transform_vertex_aabb_unit.sv =====
module tb_rigid_transform_vertex_aabb_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import rtva_pkg::*;

   localparam int QFRAC = 14;
   localparam int ERRORS_SHOWN = 10;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 200;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam longint COORD_MIN = -64'sd2147483648;
   // index past the end of the register map, writes to it are dropped
   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_payload_type        req_payload;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [COORD_W-1:0]     csr_wdata;

   // shadow of the pose registers and the running box
   longint body_x, body_y, body_z;
   longint q_w, q_x, q_y, q_z;
   longint lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
   bit     box_restart;

   rsp_payload_type world_box_queue[$];
   int unsigned     error_count;
   int unsigned     cycle_count;
   bit              idle_on;

   rigid_transform_vertex_aabb_unit #(
      .QUAT_FRAC_BITS(QFRAC)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // run time limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   // drop the quaternion fraction, round half up
   function automatic longint round_q(input longint x);
      return (x + (longint'(1) << (QFRAC - 1))) >>> QFRAC;
   endfunction

   function automatic longint clamp_coord(input longint x);
      if (x > COORD_MAX) return COORD_MAX;
      if (x < COORD_MIN) return COORD_MIN;
      return x;
   endfunction

   function automatic void reset_shadow();
      body_x = 0; body_y = 0; body_z = 0;
      q_w = longint'(1) << QFRAC;
      q_x = 0; q_y = 0; q_z = 0;
      lo_x = 0; lo_y = 0; lo_z = 0;
      hi_x = 0; hi_y = 0; hi_z = 0;
      box_restart = 1'b1;
   endfunction

   function automatic void apply_reg(input logic [CSR_INDEX_W-1:0] index,
                                     input logic [COORD_W-1:0] data);
      case (index)
         REG_POS_X:  body_x = longint'($signed(data));
         REG_POS_Y:  body_y = longint'($signed(data));
         REG_POS_Z:  body_z = longint'($signed(data));
         REG_QUAT_W: q_w = longint'($signed(data[QUAT_W-1:0]));
         REG_QUAT_X: q_x = longint'($signed(data[QUAT_W-1:0]));
         REG_QUAT_Y: q_y = longint'($signed(data[QUAT_W-1:0]));
         REG_QUAT_Z: q_z = longint'($signed(data[QUAT_W-1:0]));
         default: ;
      endcase
   endfunction

   // world vertex and box so far for one local vertex
   function automatic rsp_payload_type predict_world_box(input req_payload_type item);
      longint vx, vy, vz, ax, ay, az, sx, sy, sz, wx, wy, wz;
      rsp_payload_type r;
      vx = longint'($signed(item.vert_x));
      vy = longint'($signed(item.vert_y));
      vz = longint'($signed(item.vert_z));
      // a = u x v, back at coordinate scale
      ax = round_q(q_y * vz - q_z * vy);
      ay = round_q(q_z * vx - q_x * vz);
      az = round_q(q_x * vy - q_y * vx);
      // s = w*a + u x a, kept at full scale
      sx = q_w * ax + (q_y * az - q_z * ay);
      sy = q_w * ay + (q_z * ax - q_x * az);
      sz = q_w * az + (q_x * ay - q_y * ax);
      wx = clamp_coord(vx + round_q(2 * sx) + body_x);
      wy = clamp_coord(vy + round_q(2 * sy) + body_y);
      wz = clamp_coord(vz + round_q(2 * sz) + body_z);
      // box update, first vertex of a set starts it over
      if (box_restart) begin
         lo_x = wx; lo_y = wy; lo_z = wz;
         hi_x = wx; hi_y = wy; hi_z = wz;
      end else begin
         if (wx < lo_x) lo_x = wx;
         if (wy < lo_y) lo_y = wy;
         if (wz < lo_z) lo_z = wz;
         if (wx > hi_x) hi_x = wx;
         if (wy > hi_y) hi_y = wy;
         if (wz > hi_z) hi_z = wz;
      end
      box_restart = item.last_vertex;
      r.world_x = wx[31:0];
      r.world_y = wy[31:0];
      r.world_z = wz[31:0];
      r.box_valid = item.last_vertex;
      r.box_min_x = lo_x[31:0];
      r.box_min_y = lo_y[31:0];
      r.box_min_z = lo_z[31:0];
      r.box_max_x = hi_x[31:0];
      r.box_max_y = hi_y[31:0];
      r.box_max_z = hi_z[31:0];
      return r;
   endfunction

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic int unsigned pause_cycles();
      return idle_on ? $urandom_range(0, 10) : 0;
   endfunction

   function automatic req_payload_type make_vertex(input logic [31:0] x, y, z,
                                                   input logic last);
      req_payload_type v;
      v.vert_x = x;
      v.vert_y = y;
      v.vert_z = z;
      v.last_vertex = last;
      return v;
   endfunction

   // mostly small coordinates, some full range, some extremes
   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 9))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2, 3, 4: return $urandom;
         default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      endcase
   endfunction

   // quaternion part with junk in the unused upper half
   function automatic logic [31:0] random_quat();
      logic [31:0] q;
      case ($urandom_range(0, 5))
         0: q = 32'h0000_4000;
         1: q = $urandom;
         default: q = $urandom_range(0, 32768) - 32'd16384;
      endcase
      return {16'($urandom_range(0, 16'hffff)), q[15:0]};
   endfunction

   // one vertex item, valid stays high when the next one follows at once
   task automatic send_vertex(input req_payload_type item);
      int unsigned gap;
      gap = pause_cycles();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (req_stall);
      world_box_queue = {world_box_queue, predict_world_box(item)};
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (world_box_queue.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [COORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_reg(index, data);
   endtask

   // full register set, written once the unit is idle
   task automatic set_pose(input logic [31:0] px, py, pz, qw, qx, qy, qz);
      wait_drained();
      write_reg(REG_UNMAPPED, $urandom);
      write_reg(REG_POS_X, px);
      write_reg(REG_POS_Y, py);
      write_reg(REG_POS_Z, pz);
      write_reg(REG_QUAT_W, qw);
      write_reg(REG_QUAT_X, qx);
      write_reg(REG_QUAT_Y, qy);
      write_reg(REG_QUAT_Z, qz);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // result checking
   // ---------------------------------------------------------------

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
         error_count++;
         if (error_count <= ERRORS_SHOWN)
            $display("%0t %s: expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // compare each result, stall the result side at random
   initial begin : result_checker
      rsp_payload_type want;
      int unsigned hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (world_box_queue.size() == 0) begin
               error_count++;
               if (error_count <= ERRORS_SHOWN)
                  $display("%0t result with no item outstanding", $realtime);
            end else begin
               want = world_box_queue.pop_front();
               check_field("world_x", want.world_x, rsp_payload.world_x);
               check_field("world_y", want.world_y, rsp_payload.world_y);
               check_field("world_z", want.world_z, rsp_payload.world_z);
               check_field("box_valid", want.box_valid, rsp_payload.box_valid);
               check_field("box_min_x", want.box_min_x, rsp_payload.box_min_x);
               check_field("box_min_y", want.box_min_y, rsp_payload.box_min_y);
               check_field("box_min_z", want.box_min_z, rsp_payload.box_min_z);
               check_field("box_max_x", want.box_max_x, rsp_payload.box_max_x);
               check_field("box_max_y", want.box_max_y, rsp_payload.box_max_y);
               check_field("box_max_z", want.box_max_z, rsp_payload.box_max_z);
            end
            hold = pause_cycles();
            if (hold != 0) rsp_stall <= 1'b1;
         end else if (rsp_valid && hold != 0) begin
            hold--;
            if (hold == 0) rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // identity pose out of reset, coordinate extremes
   task automatic test_reset_pose();
      send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 1'b0));
      send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h1, 1'b0));
      send_vertex(make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 1'b1));
      // single vertex set
      send_vertex(make_vertex(32'h0000_3039, 32'hffff_e57b, 32'h0001_0000, 1'b1));
   endtask

   // position at the limits drives world coordinates into saturation
   task automatic test_saturation();
      set_pose(32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
               32'h0000_4000, 32'h0, 32'h0, 32'h0);
      send_vertex(make_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 1'b0));
      send_vertex(make_vertex(32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff, 1'b0));
      send_vertex(make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1));
      set_pose(32'h8000_0000, 32'h7fff_ffff, 32'hffff_0000,
               32'h0000_4000, 32'h0, 32'h0, 32'h0);
      send_vertex(make_vertex(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b1));
   endtask

   // quarter turn, non-unit and out-of-range quaternions
   task automatic test_rotations();
      // 90 degrees about z
      set_pose(32'h0, 32'h0, 32'h0, 32'h0000_2d41, 32'h0, 32'h0, 32'h0000_2d41);
      send_vertex(make_vertex(32'h0001_0000, 32'h0, 32'h0, 1'b0));
      send_vertex(make_vertex(32'h0, 32'h0001_0000, 32'h0, 1'b0));
      send_vertex(make_vertex(32'h0, 32'h0, 32'h0001_0000, 1'b1));
      // length above one, used unnormalized
      set_pose(32'h0002_8000, 32'hfffe_0000, 32'h0,
               32'h0, 32'h0000_4000, 32'h0000_4000, 32'h0);
      send_vertex(make_vertex(32'h0003_0000, 32'hffff_8000, 32'h0000_1234, 1'b0));
      send_vertex(make_vertex(32'hfff0_0000, 32'h0010_0000, 32'h8000_0000, 1'b1));
      // raw values past one, upper write bits must be dropped
      set_pose(32'h0, 32'h0, 32'h0,
               32'ha5a5_7fff, 32'h5a5a_8000, 32'hffff_c000, 32'h1234_4000);
      send_vertex(make_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
      send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0));
      send_vertex(make_vertex(32'h0000_8000, 32'hffff_0001, 32'h0000_0000, 1'b1));
      // negative scalar part, vertex after a closed set starts a new box
      set_pose(32'h0000_0100, 32'h0, 32'hffff_ff00,
               32'h0000_c000, 32'h0000_2000, 32'h0000_e000, 32'h0000_1000);
      send_vertex(make_vertex(32'h0005_0000, 32'h0, 32'hfffb_0000, 1'b0));
      send_vertex(make_vertex(32'hfffb_0000, 32'h0005_0000, 32'h0, 1'b1));
   endtask

   // random poses, random sets of vertices
   task automatic test_random_sets();
      int unsigned left_in_set;
      int unsigned n;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase != 0) && ($urandom_range(0, 3) != 0);
         set_pose(random_coord(), random_coord(), random_coord(),
                  random_quat(), random_quat(), random_quat(), random_quat());
         left_in_set = 0;
         n = 0;
         while (n < ITEMS_PER_PHASE || left_in_set != 0) begin
            if (left_in_set == 0)
               left_in_set = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
                                                         : $urandom_range(1, 8);
            left_in_set--;
            send_vertex(make_vertex(random_coord(), random_coord(), random_coord(),
                                    left_in_set == 0));
            n++;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      rsp_stall <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      error_count = 0;
      cycle_count = 0;
      idle_on = 1'b1;
      reset_shadow();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_pose();
      test_saturation();
      test_rotations();
      test_random_sets();

      // let the last results come back, then look for strays
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (world_box_queue.size() != 0) error_count++;
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
